FILE: hdl/biquad_cascade_df1_filter_top_defines.svh
// assertion macros for the biquad cascade, used by its sequencer bcdf_ctrl
`ifndef BIQUAD_CASCADE_DF1_FILTER_TOP_DEFINES_SVH
`define BIQUAD_CASCADE_DF1_FILTER_TOP_DEFINES_SVH

// same-cycle implication, checked on clk with reset masked
`define BCDF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk with reset masked
`define BCDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bcdf_pkg.sv
package bcdf_pkg;

  localparam int MAX_STAGES      = 4;
  localparam int SAMPLE_BITS     = 16;
  localparam int COEF_BITS       = 16;
  localparam int COEF_FRAC_BITS  = 14;
  localparam int COEFS_PER_STAGE = 5;
  localparam int STORE_DEPTH     = COEFS_PER_STAGE * MAX_STAGES;
  localparam int COEF_ADDR_BITS  = $clog2(STORE_DEPTH);
  localparam int COEF_IDX_BITS   = 5;
  localparam int STAGE_BITS      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int TAP_BITS        = 3;
  localparam int CFG_BITS        = 3;
  localparam int PROD_BITS       = SAMPLE_BITS + COEF_BITS;
  // five products summed: three guard bits
  localparam int ACC_BITS        = PROD_BITS + 3;

  localparam logic [CFG_BITS-1:0] NUM_STAGES_RESET = CFG_BITS'(1);

  localparam logic FUNC_FILTER = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  // coefficient order within one section
  localparam logic [TAP_BITS-1:0] TAP_B0 = 3'd0;
  localparam logic [TAP_BITS-1:0] TAP_B1 = 3'd1;
  localparam logic [TAP_BITS-1:0] TAP_B2 = 3'd2;
  localparam logic [TAP_BITS-1:0] TAP_A1 = 3'd3;
  localparam logic [TAP_BITS-1:0] TAP_A2 = 3'd4;

  typedef struct packed {
    logic                  sample_take;
    logic                  coef_wr;
    logic                  rd_en;
    logic [TAP_BITS-1:0]   tap;
    logic [STAGE_BITS-1:0] stage;
    logic                  acc_clr;
    logic                  stage_done;
    logic                  out_load;
  } bcdf_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } bcdf_status_t;

endpackage

FILE: hdl/bcdf_in_if.sv
interface bcdf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   func;
  logic signed [bcdf_pkg::SAMPLE_BITS-1:0] sample_in;
  logic [bcdf_pkg::COEF_IDX_BITS-1:0]      coef_index;
  logic signed [bcdf_pkg::COEF_BITS-1:0]   coef_value;
  logic                                   block_end;

  modport source (output valid, func, sample_in, coef_index, coef_value, block_end,
                  input ready);
  modport sink (input valid, func, sample_in, coef_index, coef_value, block_end,
                output ready);
endinterface

FILE: hdl/bcdf_out_if.sv
interface bcdf_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [bcdf_pkg::SAMPLE_BITS-1:0] sample_out;
  logic                                   block_end_out;

  modport source (output valid, sample_out, block_end_out, input ready);
  modport sink (input valid, sample_out, block_end_out, output ready);
endinterface

FILE: hdl/bcdf_datapath.sv
module bcdf_datapath (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  bcdf_pkg::bcdf_cmd_t                     cmd,
  output bcdf_pkg::bcdf_status_t                  status,
  input  logic signed [bcdf_pkg::SAMPLE_BITS-1:0] sample_in,
  input  logic [bcdf_pkg::COEF_IDX_BITS-1:0]      coef_index,
  input  logic signed [bcdf_pkg::COEF_BITS-1:0]   coef_value,
  input  logic                                    block_end,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [bcdf_pkg::SAMPLE_BITS-1:0] sample_out,
  output logic                                    block_end_out
);

  localparam logic signed [bcdf_pkg::ACC_BITS-1:0] ROUND_HALF =
    bcdf_pkg::ACC_BITS'(1) <<< (bcdf_pkg::COEF_FRAC_BITS - 1);
  localparam logic signed [bcdf_pkg::ACC_BITS-1:0] SAT_MAX =
    (bcdf_pkg::ACC_BITS'(1) <<< (bcdf_pkg::SAMPLE_BITS - 1)) - bcdf_pkg::ACC_BITS'(1);
  localparam logic signed [bcdf_pkg::ACC_BITS-1:0] SAT_MIN = -SAT_MAX - bcdf_pkg::ACC_BITS'(1);

  logic signed [bcdf_pkg::COEF_BITS-1:0]   coef_mem [bcdf_pkg::STORE_DEPTH];
  logic signed [bcdf_pkg::SAMPLE_BITS-1:0] xd1_r [bcdf_pkg::MAX_STAGES];
  logic signed [bcdf_pkg::SAMPLE_BITS-1:0] xd2_r [bcdf_pkg::MAX_STAGES];
  logic signed [bcdf_pkg::SAMPLE_BITS-1:0] yd1_r [bcdf_pkg::MAX_STAGES];
  logic signed [bcdf_pkg::SAMPLE_BITS-1:0] yd2_r [bcdf_pkg::MAX_STAGES];

  logic signed [bcdf_pkg::SAMPLE_BITS-1:0] x_r;
  logic                                    be_r;
  logic signed [bcdf_pkg::COEF_BITS-1:0]   coef_q_r;
  logic signed [bcdf_pkg::SAMPLE_BITS-1:0] opnd_r;
  logic signed [bcdf_pkg::SAMPLE_BITS-1:0] opnd_nxt;
  logic signed [bcdf_pkg::PROD_BITS-1:0]   prod_r;
  logic signed [bcdf_pkg::ACC_BITS-1:0]    acc_r;
  logic                                    v1_r;
  logic                                    v2_r;
  logic                                    out_valid_r;
  logic signed [bcdf_pkg::SAMPLE_BITS-1:0] out_sample_r;
  logic                                    out_be_r;

  logic [bcdf_pkg::COEF_ADDR_BITS-1:0]     rd_addr;
  logic [bcdf_pkg::COEF_ADDR_BITS-1:0]     wr_addr;
  logic                                    wr_ok;
  logic signed [bcdf_pkg::ACC_BITS-1:0]    rnd;
  logic signed [bcdf_pkg::ACC_BITS-1:0]    shifted;
  logic signed [bcdf_pkg::SAMPLE_BITS-1:0] y;

  assign rd_addr = bcdf_pkg::COEF_ADDR_BITS'(
    int'(cmd.stage) * bcdf_pkg::COEFS_PER_STAGE + int'(cmd.tap));
  assign wr_ok   = (int'(coef_index) < bcdf_pkg::STORE_DEPTH);
  assign wr_addr = bcdf_pkg::COEF_ADDR_BITS'(coef_index);

  // coefficient store, registered read
  always_ff @(posedge clk) begin
    if (cmd.coef_wr && wr_ok) begin
      coef_mem[wr_addr] <= coef_value;
    end
    if (cmd.rd_en) begin
      coef_q_r <= coef_mem[rd_addr];
    end
  end

  always_comb begin
    case (cmd.tap)
      bcdf_pkg::TAP_B0: opnd_nxt = x_r;
      bcdf_pkg::TAP_B1: opnd_nxt = xd1_r[cmd.stage];
      bcdf_pkg::TAP_B2: opnd_nxt = xd2_r[cmd.stage];
      bcdf_pkg::TAP_A1: opnd_nxt = yd1_r[cmd.stage];
      bcdf_pkg::TAP_A2: opnd_nxt = yd2_r[cmd.stage];
      default:          opnd_nxt = '0;
    endcase
  end

  // round half up, then saturate
  always_comb begin
    rnd     = acc_r + ROUND_HALF;
    shifted = rnd >>> bcdf_pkg::COEF_FRAC_BITS;
    if (shifted > SAT_MAX) begin
      y = bcdf_pkg::SAMPLE_BITS'(SAT_MAX);
    end else if (shifted < SAT_MIN) begin
      y = bcdf_pkg::SAMPLE_BITS'(SAT_MIN);
    end else begin
      y = shifted[bcdf_pkg::SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      opnd_r <= opnd_nxt;
    end
    if (v1_r) begin
      prod_r <= coef_q_r * opnd_r;
    end
    if (v2_r) begin
      acc_r <= acc_r + bcdf_pkg::ACC_BITS'(prod_r);
    end else if (cmd.acc_clr) begin
      acc_r <= '0;
    end
    if (cmd.sample_take) begin
      x_r  <= sample_in;
      be_r <= block_end;
    end else if (cmd.stage_done) begin
      x_r <= y;
    end
    if (cmd.out_load) begin
      out_sample_r <= y;
      out_be_r     <= be_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < bcdf_pkg::MAX_STAGES; i++) begin
        xd1_r[i] <= '0;
        xd2_r[i] <= '0;
        yd1_r[i] <= '0;
        yd2_r[i] <= '0;
      end
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.stage_done) begin
        xd2_r[cmd.stage] <= xd1_r[cmd.stage];
        xd1_r[cmd.stage] <= x_r;
        yd2_r[cmd.stage] <= yd1_r[cmd.stage];
        yd1_r[cmd.stage] <= y;
      end
    end
  end

  assign status.out_blocked = out_valid_r && !out_ready;
  assign out_valid          = out_valid_r;
  assign sample_out         = out_sample_r;
  assign block_end_out      = out_be_r;

endmodule

FILE: hdl/bcdf_ctrl.sv
`include "biquad_cascade_df1_filter_top_defines.svh"

module bcdf_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bcdf_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic                              in_valid,
  input  logic                              in_func,
  output logic                              in_ready,
  output bcdf_pkg::bcdf_cmd_t               cmd,
  input  bcdf_pkg::bcdf_status_t            status
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_TAP    = 5'b00010,
    S_WAIT1  = 5'b00100,
    S_WAIT2  = 5'b01000,
    S_UPDATE = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [bcdf_pkg::TAP_BITS-1:0]   tap_r, tap_nxt;
  logic [bcdf_pkg::STAGE_BITS-1:0] stage_r, stage_nxt;
  logic [bcdf_pkg::STAGE_BITS-1:0] last_r, last_nxt;
  logic [bcdf_pkg::CFG_BITS-1:0]   nst_r;
  logic [bcdf_pkg::STAGE_BITS-1:0] cfg_last;

  // clamp the section count to 1..MAX_STAGES
  always_comb begin
    if (nst_r == '0) begin
      cfg_last = '0;
    end else if (int'(nst_r) > bcdf_pkg::MAX_STAGES) begin
      cfg_last = bcdf_pkg::STAGE_BITS'(bcdf_pkg::MAX_STAGES - 1);
    end else begin
      cfg_last = bcdf_pkg::STAGE_BITS'(nst_r - 1'b1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    stage_nxt = stage_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.tap   = tap_r;
    cmd.stage = stage_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == bcdf_pkg::FUNC_LOAD) begin
            cmd.coef_wr = 1'b1;
          end else begin
            cmd.sample_take = 1'b1;
            stage_nxt       = '0;
            tap_nxt         = bcdf_pkg::TAP_B0;
            last_nxt        = cfg_last;
            state_nxt       = S_TAP;
          end
        end
      end
      S_TAP: begin
        cmd.rd_en   = 1'b1;
        cmd.acc_clr = (tap_r == bcdf_pkg::TAP_B0);
        tap_nxt     = tap_r + 1'b1;
        if (tap_r == bcdf_pkg::TAP_A2) begin
          state_nxt = S_WAIT1;
        end
      end
      S_WAIT1: begin
        state_nxt = S_WAIT2;
      end
      S_WAIT2: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (stage_r == last_r) begin
          if (!status.out_blocked) begin
            cmd.stage_done = 1'b1;
            cmd.out_load   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else begin
          cmd.stage_done = 1'b1;
          stage_nxt      = stage_r + 1'b1;
          tap_nxt        = bcdf_pkg::TAP_B0;
          state_nxt      = S_TAP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tap_r   <= bcdf_pkg::TAP_B0;
      stage_r <= '0;
      last_r  <= '0;
      nst_r   <= bcdf_pkg::NUM_STAGES_RESET;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      stage_r <= stage_nxt;
      last_r  <= last_nxt;
      if (cfg_we) begin
        nst_r <= cfg_data;
      end
    end
  end

  `BCDF_ASSERT_NEXT(a_sample_starts, in_valid && in_ready && in_func == bcdf_pkg::FUNC_FILTER, state_r == S_TAP && tap_r == bcdf_pkg::TAP_B0 && stage_r == '0, "sample did not start at first tap")
  `BCDF_ASSERT_NEXT(a_load_stays_idle, in_valid && in_ready && in_func == bcdf_pkg::FUNC_LOAD, state_r == S_IDLE, "coefficient load left idle")
  `BCDF_ASSERT_NOW(a_stage_in_range, state_r != S_IDLE, stage_r <= last_r, "stage beyond last section")
  `BCDF_ASSERT_NOW(a_no_overwrite, cmd.out_load, !status.out_blocked && stage_r == last_r, "result loaded over waiting word")

endmodule

FILE: hdl/biquad_cascade_df1_filter_top.sv
// cascade of direct-form-1 biquad sections in fixed point: samples are q1.15, coefficients
// q2.14, each section output rounded half up and saturated to 16 bits. an input word with
// func = 1 writes coef_value into slot coef_index (stage*5 + b0,b1,b2,a1,a2; slots 20 and
// up are ignored) and gives no result. a word with func = 0 runs the sample through
// sections 1..num_stages and gives one result word carrying block_end. one shared
// 16x16 multiplier handles one tap a cycle, fed by the registered coefficient store
// read, so each section is five tap reads (S_TAP), a pipeline drain (S_WAIT1, S_WAIT2)
// and one round/update (S_UPDATE). one item is worked on at a time; the next word is
// taken while the previous result still waits in the output register. num_stages is
// to be written by the user through cfg_we/cfg_data only while idle; the block does
// not enforce it. 0 counts as one section and values above four as four. coefficients
// must be loaded before a sample uses them.
module biquad_cascade_df1_filter_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bcdf_pkg::CFG_BITS-1:0]     cfg_data,
  bcdf_in_if.sink                           in_ch,
  bcdf_out_if.source                        out_ch
);

  // command and status between sequencer and datapath
  bcdf_pkg::bcdf_cmd_t    cmd;
  bcdf_pkg::bcdf_status_t status;

  // sequencer: handshake on the input side, tap and section counting
  bcdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .status   (status)
  );

  // datapath: coefficient store, delay lines, multiply-accumulate, output word register
  bcdf_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .sample_in     (in_ch.sample_in),
    .coef_index    (in_ch.coef_index),
    .coef_value    (in_ch.coef_value),
    .block_end     (in_ch.block_end),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .sample_out    (out_ch.sample_out),
    .block_end_out (out_ch.block_end_out)
  );

endmodule

FILE: tb/sv/biquad_output_checker.sv
`timescale 1ns / 100ps

module biquad_output_checker
  import bcdf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_data,
  bcdf_in_if                  in_ch,
  bcdf_out_if                 out_ch,
  output int                  mismatch_count,
  output int                  open_results
);

  localparam longint SAT_HI     = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO     = -(longint'(1) << (SAMPLE_BITS - 1));

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filt_sample;
    logic                          blk_end;
  } filt_word_t;

  // results still owed by the filter, oldest first
  filt_word_t awaited_words[$];

  logic signed [COEF_BITS-1:0]   coef_tbl [STORE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] x_d1 [MAX_STAGES];
  logic signed [SAMPLE_BITS-1:0] x_d2 [MAX_STAGES];
  logic signed [SAMPLE_BITS-1:0] y_d1 [MAX_STAGES];
  logic signed [SAMPLE_BITS-1:0] y_d2 [MAX_STAGES];
  logic [CFG_BITS-1:0]           stage_cfg;

  function automatic logic signed [SAMPLE_BITS-1:0] round_saturate(longint acc);
    longint r;
    // half up, then floor shift
    r = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    if (r > SAT_HI) r = SAT_HI;
    if (r < SAT_LO) r = SAT_LO;
    return SAMPLE_BITS'(r);
  endfunction

  // runs one sample through the sections in use and updates their delay lines
  function automatic logic signed [SAMPLE_BITS-1:0] filter_sample(
    logic signed [SAMPLE_BITS-1:0] x_in
  );
    int                            n_used;
    int                            s;
    int                            base;
    longint                        acc;
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] y;
    n_used = int'(stage_cfg);
    if (n_used == 0) n_used = 1;
    if (n_used > MAX_STAGES) n_used = MAX_STAGES;
    x = x_in;
    for (s = 0; s < n_used; s++) begin
      base = s * COEFS_PER_STAGE;
      acc = longint'(coef_tbl[base + TAP_B0]) * longint'(x)
          + longint'(coef_tbl[base + TAP_B1]) * longint'(x_d1[s])
          + longint'(coef_tbl[base + TAP_B2]) * longint'(x_d2[s])
          + longint'(coef_tbl[base + TAP_A1]) * longint'(y_d1[s])
          + longint'(coef_tbl[base + TAP_A2]) * longint'(y_d2[s]);
      y = round_saturate(acc);
      x_d2[s] = x_d1[s];
      x_d1[s] = x;
      y_d2[s] = y_d1[s];
      y_d1[s] = y;
      x = y;
    end
    return x;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    filt_word_t want_word;
    if (!rst_n) begin
      for (int s = 0; s < MAX_STAGES; s++) begin
        x_d1[s] = '0;
        x_d2[s] = '0;
        y_d1[s] = '0;
        y_d2[s] = '0;
      end
      stage_cfg = NUM_STAGES_RESET;
      awaited_words.delete();
      mismatch_count = 0;
      open_results <= 0;
    end else begin
      if (cfg_we) stage_cfg = cfg_data;

      if (out_ch.valid && out_ch.ready) begin
        if (awaited_words.size() == 0) begin
          report_mismatch($sformatf("result word %0d/%0b with no sample waiting",
                                    out_ch.sample_out, out_ch.block_end_out));
        end else begin
          want_word = awaited_words.pop_front();
          if (out_ch.sample_out !== want_word.filt_sample)
            report_mismatch($sformatf("sample_out %0d, expected %0d",
                                      out_ch.sample_out, want_word.filt_sample));
          if (out_ch.block_end_out !== want_word.blk_end)
            report_mismatch($sformatf("block_end_out %0b, expected %0b",
                                      out_ch.block_end_out, want_word.blk_end));
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.func == FUNC_LOAD) begin
          if (in_ch.coef_index < STORE_DEPTH) coef_tbl[in_ch.coef_index] = in_ch.coef_value;
        end else begin
          want_word.filt_sample = filter_sample(in_ch.sample_in);
          want_word.blk_end     = in_ch.block_end;
          awaited_words.push_back(want_word);
        end
      end

      open_results <= awaited_words.size();
    end
  end

endmodule

FILE: tb/sv/tb_biquad_cascade_df1_filter_top.sv
`timescale 1ns / 100ps

module tb_biquad_cascade_df1_filter_top;
  import bcdf_pkg::*;

  // settle time covering a sample through every section, plus a little margin
  localparam int SETTLE_CYCLES   = 1 + 8 * MAX_STAGES + 8;
  // quiet cycles allowed before the run is declared hung
  localparam int STALL_LIMIT     = 1000;
  localparam int WORDS_PER_PHASE = 130;
  localparam int MAX_WAIT        = 16;

  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [COEF_BITS-1:0]   COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic signed [COEF_BITS-1:0]   COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam logic signed [COEF_BITS-1:0]   COEF_ONE = COEF_BITS'(1 << COEF_FRAC_BITS);

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_data;

  int mismatch_count;
  int open_results;
  int quiet_cycles = 0;
  int sample_words = 0;
  int load_words   = 0;
  int cfg_writes   = 0;
  bit steady_flow  = 1'b0;   // when set neither side idles

  bcdf_in_if  in_ch();
  bcdf_out_if out_ch();

  biquad_cascade_df1_filter_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // prediction and comparison live in the checker; this module only drives
  biquad_output_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .open_results   (open_results)
  );

  always #2 clk = ~clk;

  // per-word idle draw, shared by both sides
  function automatic int idle_cycles();
    return steady_flow ? 0 : int'($urandom_range(MAX_WAIT, 0));
  endfunction

  // valid is only lowered when a gap is drawn, so back-to-back words never
  // see valid dropped and raised in the same step
  task automatic send_word(logic func, logic signed [SAMPLE_BITS-1:0] smp,
                           logic [COEF_IDX_BITS-1:0] idx,
                           logic signed [COEF_BITS-1:0] val, logic blk);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= func;
    in_ch.sample_in  <= smp;
    in_ch.coef_index <= idx;
    in_ch.coef_value <= val;
    in_ch.block_end  <= blk;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (func == FUNC_LOAD) load_words++;
    else sample_words++;
  endtask

  // fields that the operation ignores carry random filler
  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] smp, logic blk);
    send_word(FUNC_FILTER, smp, COEF_IDX_BITS'($urandom), COEF_BITS'($urandom), blk);
  endtask

  task automatic send_load(logic [COEF_IDX_BITS-1:0] idx, logic signed [COEF_BITS-1:0] val);
    send_word(FUNC_LOAD, SAMPLE_BITS'($urandom), idx, val, 1'($urandom));
  endtask

  // stop sending, wait for every owed result, then let a trailing load finish
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_stages(logic [CFG_BITS-1:0] n);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cfg_writes++;
  endtask

  // one section's five words: either a stable design or any bit pattern at all
  task automatic load_section(int stage, bit wild);
    logic signed [COEF_BITS-1:0] tap_val [COEFS_PER_STAGE];
    int pole_mag;
    int a1_lim;
    int t;
    // poles of z^2 - a1 z - a2 stay inside the unit circle for these ranges
    pole_mag = $urandom_range(14000, 0);
    a1_lim   = 16384 + pole_mag - 1500;
    for (t = 0; t < COEFS_PER_STAGE; t++) tap_val[t] = COEF_BITS'($urandom);
    if (!wild) begin
      tap_val[TAP_B0] = COEF_BITS'(int'($urandom_range(16384, 0)) - 8192);
      tap_val[TAP_B1] = COEF_BITS'(int'($urandom_range(16384, 0)) - 8192);
      tap_val[TAP_B2] = COEF_BITS'(int'($urandom_range(16384, 0)) - 8192);
      tap_val[TAP_A1] = COEF_BITS'(int'($urandom_range(2 * a1_lim, 0)) - a1_lim);
      tap_val[TAP_A2] = COEF_BITS'(-pole_mag);
    end
    for (t = 0; t < COEFS_PER_STAGE; t++)
      send_load(COEF_IDX_BITS'(stage * COEFS_PER_STAGE + t), tap_val[t]);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(9, 0))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2, 3:    return SAMPLE_BITS'(int'($urandom_range(512, 0)) - 256);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // mostly sample blocks closed by block_end, with section reloads, stray
  // loads (some outside the store), drains and the odd misplaced block_end mixed in
  task automatic run_random_phase(int n_words);
    int sent;
    int pick;
    int blk_len;
    int i;
    sent = 0;
    while (sent < n_words) begin
      pick        = $urandom_range(99, 0);
      steady_flow = ($urandom_range(4, 0) == 0);
      if (pick < 8) begin
        load_section($urandom_range(MAX_STAGES - 1, 0), $urandom_range(9, 0) < 3);
        sent += COEFS_PER_STAGE;
      end else if (pick < 13) begin
        send_load(COEF_IDX_BITS'($urandom), COEF_BITS'($urandom));
        sent++;
      end else if (pick < 15) begin
        // hold the sender until the filter has handed back everything
        drain();
      end else begin
        blk_len = $urandom_range(16, 1);
        for (i = 0; i < blk_len; i++) begin
          send_sample(pick_sample(), (i == blk_len - 1) ^ ($urandom_range(19, 0) == 0));
          sent++;
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  // result side: a fresh stall draw before every word
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // watchdog on cycles where neither channel moves a word
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no word moved for %0d cycles, giving up", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CFG_BITS-1:0] stage_plan [10];
    int p;
    int s;
    // both extremes of the legal range, zero and the saturating values included
    stage_plan = '{4, 1, 0, 7, 3, 2, 5, 6, 4, 1};

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_FILTER;
    in_ch.sample_in  <= '0;
    in_ch.coef_index <= '0;
    in_ch.coef_value <= '0;
    in_ch.block_end  <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // every slot is written before any sample reads it: unity pass-through
    for (s = 0; s < STORE_DEPTH; s++)
      send_load(COEF_IDX_BITS'(s), (s % COEFS_PER_STAGE == TAP_B0) ? COEF_ONE : '0);

    // directed part, one section in use from reset
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b0);
    send_sample('0, 1'b0);
    send_sample(1, 1'b0);
    send_sample(-1, 1'b1);

    // largest positive gain saturates both ways
    send_load(COEF_IDX_BITS'(TAP_B0), COEF_MAX);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b1);

    // most negative gain: minus full scale flips to plus full scale
    send_load(COEF_IDX_BITS'(TAP_B0), COEF_MIN);
    send_sample(SMP_MIN, 1'b0);
    send_sample(SMP_MAX, 1'b1);

    // smallest gain shows rounding half up at the boundary
    send_load(COEF_IDX_BITS'(TAP_B0), 1);
    send_sample(8192, 1'b0);
    send_sample(-8192, 1'b0);
    send_sample(-8193, 1'b0);
    send_sample(8191, 1'b1);

    // loads past the end of the store are ignored
    send_load(COEF_IDX_BITS'(STORE_DEPTH), COEF_MAX);
    send_load({COEF_IDX_BITS{1'b1}}, COEF_MIN);

    // unity feedback makes an integrator that runs into the rails
    send_load(COEF_IDX_BITS'(TAP_B0), COEF_ONE);
    send_load(COEF_IDX_BITS'(TAP_A1), COEF_ONE);
    send_sample(20000, 1'b0);
    send_sample(20000, 1'b0);
    send_sample(SMP_MIN, 1'b1);
    send_load(COEF_IDX_BITS'(TAP_A1), '0);

    // random phases over the stage-count settings
    for (p = 0; p < 10; p++) begin
      write_stages(stage_plan[p]);
      run_random_phase(WORDS_PER_PHASE);
    end

    drain();
    $display("sent %0d sample words and %0d coefficient loads", sample_words, load_words);
    $display("covered %0d stage-count settings from 0 to 7, with saturation and idling",
             cfg_writes);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/bcdf_pkg.sv
hdl/bcdf_in_if.sv
hdl/bcdf_out_if.sv
hdl/bcdf_datapath.sv
hdl/bcdf_ctrl.sv
hdl/biquad_cascade_df1_filter_top.sv
tb/sv/biquad_output_checker.sv
tb/sv/tb_biquad_cascade_df1_filter_top.sv
